>>> hw/rtl/integer_alu_floor_divide_defines.svh
// Assertion macros used by the checker file.
`ifndef INTEGER_ALU_FLOOR_DIVIDE_DEFINES_SVH
`define INTEGER_ALU_FLOOR_DIVIDE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define IAFD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define IAFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hw/rtl/iafd_pkg.sv
// ----------------------------------------------------------------------------
// iafd_pkg
// Shared types and constants of the integer ALU with floor division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package iafd_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int ACT_W = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_LT  = 3'd4,
        ACT_GT  = 3'd5
    } action_t;

    // Per-item control carried down the divider chain
    typedef struct packed {
        logic       vld;
        logic [ACT_W-1:0] act;
        logic       neg_q;   // quotient sign differs
        logic       dz;      // divisor zero
    } ctl_t;
endpackage

>>> hw/rtl/iafd_div_cell.sv
// ----------------------------------------------------------------------------
// iafd_div_cell
// One restoring division step: shifts in one dividend bit, trial subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iafd_div_cell #(
    parameter int W = iafd_pkg::DATA_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  iafd_pkg::ctl_t   ctl_in,
    input  logic [W-1:0]     rem_in,
    input  logic [W-1:0]     quo_in,   // dividend bits shifted out as quotient fills
    input  logic [W-1:0]     dsr_in,
    input  logic [W-1:0]     res_in,   // non-divide result riding along
    output iafd_pkg::ctl_t   ctl_out,
    output logic [W-1:0]     rem_out,
    output logic [W-1:0]     quo_out,
    output logic [W-1:0]     dsr_out,
    output logic [W-1:0]     res_out
);
    import iafd_pkg::*;

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         take;
    ctl_t         ctl_reg;
    logic [W-1:0] rem_reg, quo_reg, dsr_reg, res_reg;

    // Trial subtraction
    assign trial = {rem_in, quo_in[W-1]};
    assign diff  = trial - {1'b0, dsr_in};
    assign take  = !diff[W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= take ? diff[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_in[W-2:0], take};
            dsr_reg <= dsr_in;
            res_reg <= res_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign dsr_out = dsr_reg;
    assign res_out = res_reg;
endmodule

>>> hw/rtl/integer_alu_floor_divide.sv
// ----------------------------------------------------------------------------
// integer_alu_floor_divide
// Signed ALU: add, subtract, multiply, floor divide, less/greater compare.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries s_action, s_left_operand and
//   s_right_operand; result channel m_valid/m_ready carries m_value,
//   m_is_boolean and m_status. One result per input transfer, in order.
//   The result passes the input stage, one restoring-division cell per
//   quotient bit, then the output register with the floor fix-up in front
//   of it.
//   Throughput is one transfer per cycle unless the receiver stalls: every
//   op travels the same cell chain, set by the divider's one-bit-per-cell row.
//   The whole chain advances when the output register is empty or being
//   taken, so a stalled receiver holds every stage and drops s_ready.
//   Synchronous active-low reset clears all valid flags; nothing is in
//   flight after reset. Multiply is formed in the input stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module integer_alu_floor_divide #(
    parameter int DATA_WIDTH = iafd_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [iafd_pkg::ACT_W-1:0]   s_action,
    input  logic signed [DATA_WIDTH-1:0] s_left_operand,
    input  logic signed [DATA_WIDTH-1:0] s_right_operand,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_value,
    output logic                         m_is_boolean,
    output logic                         m_status
);
    import iafd_pkg::*;
    localparam int W = DATA_WIDTH;

    logic         adv;
    ctl_t         ctl_c [W+1];
    logic [W-1:0] rem_c [W+1];
    logic [W-1:0] quo_c [W+1];
    logic [W-1:0] dsr_c [W+1];
    logic [W-1:0] res_c [W+1];

    ctl_t         ctl0_reg;
    logic [W-1:0] quo0_reg, dsr0_reg, res0_reg, prod_reg;
    logic [W-1:0] a_mag, b_mag, res_pre;
    logic         a_neg, b_neg;
    ctl_t         ctl_next;

    logic         out_vld_reg;
    logic [W-1:0] out_val_reg;
    logic         out_bool_reg, out_stat_reg;
    logic [W-1:0] q_fix;

    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;

    // Input stage: magnitudes and the cheap results
    assign a_neg = s_left_operand[W-1];
    assign b_neg = s_right_operand[W-1];
    assign a_mag = a_neg ? W'(-s_left_operand) : s_left_operand;
    assign b_mag = b_neg ? W'(-s_right_operand) : s_right_operand;

    always_comb begin
        res_pre = '0;
        case (s_action)
            ACT_ADD: res_pre = s_left_operand + s_right_operand;
            ACT_SUB: res_pre = s_left_operand - s_right_operand;
            ACT_LT:  res_pre = W'(s_left_operand < s_right_operand);
            ACT_GT:  res_pre = W'(s_left_operand > s_right_operand);
            default: res_pre = '0;
        endcase
        ctl_next.vld   = s_valid;
        ctl_next.act   = s_action;
        ctl_next.neg_q = a_neg ^ b_neg;
        ctl_next.dz    = (s_right_operand == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl0_reg <= '0;
        end else if (adv) begin
            ctl0_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            quo0_reg <= a_mag;
            dsr0_reg <= b_mag;
            res0_reg <= res_pre;
            prod_reg <= W'(s_left_operand * s_right_operand);
        end
    end

    // Multiply result joins the ride-along path at the chain head
    assign ctl_c[0] = ctl0_reg;
    assign rem_c[0] = '0;
    assign quo_c[0] = quo0_reg;
    assign dsr_c[0] = dsr0_reg;
    assign res_c[0] = (ctl0_reg.act == ACT_MUL) ? prod_reg : res0_reg;

    for (genvar i = 0; i < W; i++) begin : g_cell
        iafd_div_cell #(.W(W)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .ctl_in  (ctl_c[i]),
            .rem_in  (rem_c[i]),
            .quo_in  (quo_c[i]),
            .dsr_in  (dsr_c[i]),
            .res_in  (res_c[i]),
            .ctl_out (ctl_c[i+1]),
            .rem_out (rem_c[i+1]),
            .quo_out (quo_c[i+1]),
            .dsr_out (dsr_c[i+1]),
            .res_out (res_c[i+1])
        );
    end

    // Floor fix-up for a negative quotient: negate, and bump magnitude when a remainder is left
    assign q_fix = ctl_c[W].neg_q
                 ? W'(-(quo_c[W] + W'(rem_c[W] != '0)))
                 : quo_c[W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= ctl_c[W].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (ctl_c[W].act == ACT_DIV) begin
                out_val_reg  <= ctl_c[W].dz ? '0 : q_fix;
                out_stat_reg <= ctl_c[W].dz;
            end else begin
                out_val_reg  <= res_c[W];
                out_stat_reg <= 1'b0;
            end
            out_bool_reg <= (ctl_c[W].act == ACT_LT) || (ctl_c[W].act == ACT_GT);
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_value      = out_val_reg;
    assign m_is_boolean = out_bool_reg;
    assign m_status     = out_stat_reg;
endmodule

>>> hw/rtl/iafd_checker.sv
// ----------------------------------------------------------------------------
// iafd_checker
// Port-level checks on the ALU's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_alu_floor_divide_defines.svh"
module iafd_checker #(
    parameter int DATA_WIDTH = iafd_pkg::DATA_WIDTH_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [DATA_WIDTH-1:0] m_value,
    input logic                  m_is_boolean,
    input logic                  m_status
);
    // Boolean results are 0 or 1
    `IAFD_ASSERT_IMPL(a_bool_val, aclk, aresetn, m_valid && m_is_boolean,
        m_value[DATA_WIDTH-1:1] == '0, "boolean result out of range")
    // Divide-by-zero result is zero and not boolean
    `IAFD_ASSERT_IMPL(a_dz_val, aclk, aresetn, m_valid && m_status,
        (m_value == '0) && !m_is_boolean, "bad divide-by-zero result")
    // Stalled output blocks input
    `IAFD_ASSERT_IMPL(a_stall, aclk, aresetn, m_valid && !m_ready,
        !s_ready, "input taken while output stalled")
    // Stalled result holds
    `IAFD_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_value), "stalled result changed")
endmodule

bind integer_alu_floor_divide iafd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_iafd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_value      (m_value),
    .m_is_boolean (m_is_boolean),
    .m_status     (m_status)
);
